// ===== rtl/periodic_timer_bank_top_assert.svh =====
// Assertion macros for the periodic timer bank.
// Used by periodic_timer_bank_top; needs a clock and a reset in scope at each use.
`ifndef PERIODIC_TIMER_BANK_TOP_ASSERT_SVH
`define PERIODIC_TIMER_BANK_TOP_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("periodic timer bank check failed");

// next-cycle implication
`define PTB_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("periodic timer bank check failed");

`endif

// ===== rtl/ptb_pkg.sv =====
// Package for the periodic timer bank: sizes, item kinds and beat structs.
// No dependencies; imported by ptb_cell and periodic_timer_bank_top.
`default_nettype none

package ptb_pkg;

  localparam int NUM_CHANNELS = 10;
  localparam int CHANNEL_W    = 4;
  localparam int VALUE_W      = 16;
  localparam int TICKS_W      = 32;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_SET   = 2'd1;
  localparam kind_t KIND_CHECK = 2'd2;
  localparam kind_t KIND_READ  = 2'd3;

  typedef struct packed {
    kind_t                kind;
    logic [CHANNEL_W-1:0] channel;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic               expired;
    logic [TICKS_W-1:0] tick_count;
  } result_t;

  // command travelling along the chain of cells
  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [CHANNEL_W-1:0] channel;
    logic [VALUE_W-1:0]   value;
    logic                 expired;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/ptb_cell.sv =====
// One timer channel of the bank: preset, count and sticky expiry flag.
// Applies the command passing through and hands it on; uses ptb_pkg.
`default_nettype none

module ptb_cell (
  input  wire                              clk,
  input  wire                              rst,
  input  wire logic [ptb_pkg::CHANNEL_W-1:0] idx,
  input  wire ptb_pkg::op_t                op_in,
  output ptb_pkg::op_t                     op_out
);
  import ptb_pkg::*;

  logic [VALUE_W-1:0] preset;
  logic [VALUE_W-1:0] count;
  logic               flag;
  logic               hit;

  assign hit = op_in.valid && (op_in.channel == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      preset <= '0;
      count  <= '0;
      flag   <= 1'b0;
    end else if (op_in.valid) begin
      case (op_in.kind)
        KIND_TICK: begin
          if (count != '0) begin
            if (count == VALUE_W'(1)) begin
              flag <= 1'b1;
            end
            count <= count - VALUE_W'(1);
          end else begin
            count <= preset;
          end
        end
        KIND_SET: begin
          if (hit) begin
            preset <= op_in.value;
            count  <= op_in.value;
          end
        end
        KIND_CHECK: begin
          if (hit) begin
            flag <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_out.valid <= 1'b0;
    end else begin
      op_out.valid <= op_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    op_out.kind    <= op_in.kind;
    op_out.channel <= op_in.channel;
    op_out.value   <= op_in.value;
    op_out.expired <= op_in.expired | (hit && (op_in.kind == KIND_CHECK) && flag);
  end

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_bank_top.sv =====
// Top level of the periodic timer bank: tick counter and a chain of timer cells.
// Depends on ptb_pkg, ptb_cell and periodic_timer_bank_top_assert.svh.
//
// Usage:
//   A command beat (cmd: kind, channel, value) is taken at a rising edge with
//   start high and busy low. Kinds: tick, set channel, check and clear flag,
//   read tick count.
//   The command walks the row of channel cells, one cell per cycle; each cell
//   applies it to its own channel. After the last cell the result beat
//   (expired, tick_count) stands on result for exactly one cycle with done high.
//   Only one command is in flight at a time; busy is high from the cycle after
//   the accept through the done cycle, so the next command may be taken one edge
//   after the edge that ends the done cycle.
//   Reset (rst, synchronous, active high) clears all presets, counts, flags, the
//   tick count and any command in flight.
//   The receiver cannot stall: a result beat not taken in its done cycle is gone.
`default_nettype none

module periodic_timer_bank_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire ptb_pkg::cmd_t    cmd,
  output logic                  done,
  output ptb_pkg::result_t      result
);
  import ptb_pkg::*;

  `include "periodic_timer_bank_top_assert.svh"

  op_t                     link [NUM_CHANNELS+1];
  logic [NUM_CHANNELS-1:0] live;
  logic [TICKS_W-1:0]      ticks;
  logic                    accept;

  assign accept = start && !busy;

  assign link[0].valid   = accept;
  assign link[0].kind    = cmd.kind;
  assign link[0].channel = cmd.channel;
  assign link[0].value   = cmd.value;
  assign link[0].expired = 1'b0;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    ptb_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .idx    (CHANNEL_W'(i)),
      .op_in  (link[i]),
      .op_out (link[i+1])
    );
    assign live[i] = link[i+1].valid;
  end

  assign busy = |live;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '0;
    end else if (accept && (cmd.kind == KIND_TICK)) begin
      ticks <= ticks + TICKS_W'(1);
    end
  end

  assign done              = link[NUM_CHANNELS].valid;
  assign result.expired    = link[NUM_CHANNELS].expired;
  assign result.tick_count = ticks;

  `PTB_ASSERT_NOW(a_one_in_flight, clk, rst, 1'b1, $onehot0(live))
  `PTB_ASSERT_NOW(a_done_latency, clk, rst, accept, ##(NUM_CHANNELS) done)
  `PTB_ASSERT_NEXT(a_tick_step, clk, rst, accept && (cmd.kind == KIND_TICK),
                   ticks == $past(ticks) + TICKS_W'(1))
  `PTB_ASSERT_NEXT(a_ticks_hold, clk, rst, !(accept && (cmd.kind == KIND_TICK)),
                   $stable(ticks))
  `PTB_ASSERT_NOW(a_expired_check, clk, rst, done && result.expired,
                  link[NUM_CHANNELS].kind == KIND_CHECK)

endmodule

`default_nettype wire

// ===== tb/ptb_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the periodic timer bank: models the channel bank and tick count,
// queues the expected result beat per command beat and compares. Depends on ptb_pkg.
module ptb_checker
  import ptb_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  input  wire     busy,
  input  cmd_t    cmd,
  input  wire     done,
  input  result_t result,
  output int      mismatches,
  output int      outstanding
);

  logic [VALUE_W-1:0] preset_m [NUM_CHANNELS];
  logic [VALUE_W-1:0] count_m  [NUM_CHANNELS];
  logic               flag_m   [NUM_CHANNELS];
  logic [TICKS_W-1:0] ticks_m;
  result_t            expected_results [$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic result_t apply_command(input cmd_t c);
    result_t r;
    logic    in_range;
    r = '0;
    in_range = c.channel < NUM_CHANNELS;
    case (c.kind)
      KIND_TICK: begin
        ticks_m = ticks_m + 1'b1;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          if (count_m[ch] != '0) begin
            if (count_m[ch] == VALUE_W'(1)) flag_m[ch] = 1'b1;
            count_m[ch] = count_m[ch] - 1'b1;
          end else begin
            count_m[ch] = preset_m[ch];
          end
        end
      end
      KIND_SET: begin
        if (in_range) begin
          preset_m[c.channel] = c.value;
          count_m[c.channel]  = c.value;
        end
      end
      KIND_CHECK: begin
        if (in_range && flag_m[c.channel]) begin
          flag_m[c.channel] = 1'b0;
          r.expired = 1'b1;
        end
      end
      default: ;
    endcase
    r.tick_count = ticks_m;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        preset_m[ch] = '0;
        count_m[ch]  = '0;
        flag_m[ch]   = 1'b0;
      end
      ticks_m = '0;
      expected_results.delete();
    end else begin
      if (start && !busy) expected_results.push_back(apply_command(cmd));
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (result.expired !== want.expired)
            report_mismatch($sformatf("expired got %b want %b",
                                      result.expired, want.expired));
          if (result.tick_count !== want.tick_count)
            report_mismatch($sformatf("tick_count got %0h want %0h",
                                      result.tick_count, want.tick_count));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/periodic_timer_bank_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the periodic timer bank: drives directed then bursty random
// command beats and gives the verdict. Depends on ptb_pkg, ptb_checker and the RTL.
module periodic_timer_bank_top_tb;
  import ptb_pkg::*;

  localparam int ITEMS          = 1350;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int CHANNEL_MAX    = (1 << CHANNEL_W) - 1;

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;
  int      mismatches;
  int      outstanding;

  periodic_timer_bank_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  ptb_checker bank_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic cmd_t make_command(input kind_t k, input int ch, input int val);
    cmd_t c;
    c.kind    = k;
    c.channel = ch[CHANNEL_W-1:0];
    c.value   = val[VALUE_W-1:0];
    return c;
  endfunction

  // hold the beat until it is taken
  task automatic send_beat(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    cmd_t directed [$];
    cmd_t c;
    int   sent;
    int   burst;
    int   sel;
    directed = '{
      make_command(KIND_READ,  15, 'hFFFF),
      make_command(KIND_CHECK, 15, 'hFFFF),
      make_command(KIND_CHECK, 0,  0),
      make_command(KIND_SET,   0,  1),
      make_command(KIND_SET,   9,  'hFFFF),
      make_command(KIND_SET,   10, 5),
      make_command(KIND_SET,   15, 'hAAAA),
      make_command(KIND_SET,   1,  0),
      make_command(KIND_SET,   2,  2),
      make_command(KIND_TICK,  7,  'h1234),
      make_command(KIND_CHECK, 0,  'hFFFF),
      make_command(KIND_CHECK, 0,  0),
      make_command(KIND_TICK,  0,  0),
      make_command(KIND_TICK,  15, 'hFFFF),
      make_command(KIND_CHECK, 2,  0),
      make_command(KIND_CHECK, 1,  0),
      make_command(KIND_CHECK, 10, 0),
      make_command(KIND_SET,   5,  'h5555),
      make_command(KIND_TICK,  10, 'hAAAA),
      make_command(KIND_READ,  10, 0),
      make_command(KIND_CHECK, 9,  0),
      make_command(KIND_SET,   9,  0),
      make_command(KIND_TICK,  0,  0)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_beat(directed[i]);

    sent = 0;
    while (sent < ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        sel = $urandom_range(0, 99);
        c = cmd_t'($urandom);
        if (sel < 45) begin
          c.kind = KIND_TICK;
        end else if (sel < 65) begin
          c.kind    = KIND_SET;
          c.channel = CHANNEL_W'(($urandom_range(0, 4) == 0) ?
                                 $urandom_range(NUM_CHANNELS, CHANNEL_MAX) :
                                 $urandom_range(0, NUM_CHANNELS - 1));
          c.value   = VALUE_W'(($urandom_range(0, 7) == 0) ? $urandom :
                               $urandom_range(0, 6));
        end else if (sel < 90) begin
          c.kind    = KIND_CHECK;
          c.channel = CHANNEL_W'(($urandom_range(0, 4) == 0) ?
                                 $urandom_range(NUM_CHANNELS, CHANNEL_MAX) :
                                 $urandom_range(0, NUM_CHANNELS - 1));
        end else begin
          c.kind = KIND_READ;
        end
        send_beat(c);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        cmd   <= cmd_t'($urandom);
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (NUM_CHANNELS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
